### rtl/arp_pkg.sv
// Shared types and codes for the ARP cache table.
// No dependencies; imported by arp_cell and arp_cache_table.
`default_nettype none

package arp_pkg;

	localparam int unsigned ENTRIES_DEF = 16;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_DEL  = 2'd1;
	localparam logic [1:0] MODE_FIND = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] target_ip;
		logic [47:0] hw_addr;
		logic [15:0] ttl_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] found_hw_addr;
		logic [15:0] found_ttl;
		logic [4:0]  entry_count;
	} rsp_t;

	// one table entry, as held in a cell and shifted between neighbors
	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [15:0] ttl;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic        add_en;
		logic        del_en;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [15:0] ttl;
	} cell_cmd_t;

endpackage

`default_nettype wire

### rtl/arp_cell.sv
// One slot of the ARP cache table: holds an entry, compares it against the
// broadcast IP and loads either a new entry or its younger neighbor.
// Depends on arp_pkg.
`default_nettype none

module arp_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire arp_pkg::cell_cmd_t cmd,
	input  wire logic               older_hit,
	input  wire logic               older_valid,
	input  wire arp_pkg::entry_t    younger,
	output logic                    hit,
	output logic                    take,
	output arp_pkg::entry_t         entry
);
	import arp_pkg::*;

	logic        valid_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [15:0] ttl_q;
	logic        match;
	logic        shift_in;
	logic        load_new;

	assign match    = valid_q && (ip_q == cmd.ip);
	assign hit      = older_hit | match;
	assign take     = match & ~older_hit;
	assign shift_in = cmd.del_en & hit;
	// first empty slot after the valid prefix takes the new entry
	assign load_new = cmd.add_en & ~valid_q & older_valid;
	assign entry    = {valid_q, ip_q, mac_q, ttl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_in) begin
			valid_q <= younger.valid;
		end else if (load_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_in) begin
			ip_q  <= younger.ip;
			mac_q <= younger.mac;
			ttl_q <= younger.ttl;
		end else if (load_new) begin
			ip_q  <= cmd.ip;
			mac_q <= cmd.mac;
			ttl_q <= cmd.ttl;
		end
	end

endmodule

`default_nettype wire

### rtl/arp_cache_table.sv
// Top level of the ARP cache table: a row of arp_cell slots, the entry
// counter and the result register. Depends on arp_pkg and arp_cell.
//
// Entries are kept oldest first in a row of ENTRIES cells, slot 0 the oldest.
// Every cell compares its IP with the request in parallel; a hit flag ripples
// from older to younger cells so only the oldest match answers a find or is
// removed by a delete, the younger cells each taking their neighbor's entry
// in the same edge. An add lands in the first empty cell. One item is accepted
// per cycle and its result appears in the output register on the next cycle;
// req_stall rises only while a finished result is held by rsp_stall. The
// table is empty after reset and needs no clearing time.
`default_nettype none

module arp_cache_table #(
	parameter int unsigned ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire arp_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output arp_pkg::rsp_t      rsp
);
	import arp_pkg::*;

	localparam int unsigned CW = $clog2(ENTRIES + 1);

	entry_t    cell_entry [ENTRIES];
	entry_t    cell_next  [ENTRIES];
	logic      cell_hit   [ENTRIES+1];
	logic      cell_vld   [ENTRIES+1];
	logic      cell_take  [ENTRIES];
	cell_cmd_t cmd;

	logic          accept;
	logic          full;
	logic          any_hit;
	logic [CW-1:0] cnt_q;
	logic [CW+4:0] cnt_ext;
	logic [47:0]   sel_mac;
	logic [15:0]   sel_ttl;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign full      = cell_entry[ENTRIES-1].valid;
	assign any_hit   = cell_hit[ENTRIES];

	assign cmd.add_en = accept && (req.mode == MODE_ADD) && !full;
	assign cmd.del_en = accept && (req.mode == MODE_DEL) && any_hit;
	assign cmd.ip     = req.target_ip;
	assign cmd.mac    = req.hw_addr;
	assign cmd.ttl    = req.ttl_value;

	assign cell_hit[0] = 1'b0;
	assign cell_vld[0] = 1'b1;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_last
			assign cell_next[i] = '0;
		end else begin : g_mid
			assign cell_next[i] = cell_entry[i+1];
		end
		assign cell_vld[i+1] = cell_entry[i].valid;

		arp_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.older_hit   (cell_hit[i]),
			.older_valid (cell_vld[i]),
			.younger     (cell_next[i]),
			.hit         (cell_hit[i+1]),
			.take        (cell_take[i]),
			.entry       (cell_entry[i])
		);
	end

	// at most one cell takes, so an OR gathers its data
	always_comb begin
		sel_mac = '0;
		sel_ttl = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (cell_take[i]) begin
				sel_mac = sel_mac | cell_entry[i].mac;
				sel_ttl = sel_ttl | cell_entry[i].ttl;
			end
		end
	end

	assign cnt_ext = {5'b0, cnt_q};

	always_comb begin
		rsp_d.status        = ST_OK;
		rsp_d.found_hw_addr = '0;
		rsp_d.found_ttl     = '0;
		rsp_d.entry_count   = cnt_ext[4:0];
		unique case (req.mode)
			MODE_ADD: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					rsp_d.entry_count = cnt_ext[4:0] + 5'd1;
				end
			end
			MODE_DEL: begin
				if (!any_hit) begin
					rsp_d.status = ST_MISS;
				end else begin
					rsp_d.entry_count = cnt_ext[4:0] - 5'd1;
				end
			end
			MODE_FIND: begin
				if (!any_hit) begin
					rsp_d.status = ST_MISS;
				end else begin
					rsp_d.found_hw_addr = sel_mac;
					rsp_d.found_ttl     = sel_ttl;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.add_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.del_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### bench/tb_arp_cache_table.sv
`timescale 1ns / 100ps
// Testbench for arp_cache_table: a shadow table predicts every reply, and a
// monitor compares the replies. Depends on arp_pkg and the arp_cache_table RTL.

module tb_arp_cache_table;
	import arp_pkg::*;

	localparam logic [1:0] MODE_NOP = 2'd3;	// unused code, must leave the table alone
	localparam int unsigned STALL_LIMIT = 500;
	localparam int unsigned RANDOM_ITEMS = 950;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [15:0] ttl;
	} slot_t;

	// shadow copy of the table, oldest entry first, plus the replies it predicts
	class arp_shadow_table;
		slot_t slots[$];
		rsp_t  replies[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		function int waiting();
			return replies.size();
		endfunction

		function void apply_request(req_t r);
			rsp_t  e;
			slot_t s;
			int    hit;
			e = '0;
			hit = -1;
			foreach (slots[i])
				if (hit < 0 && slots[i].ip == r.target_ip)
					hit = i;
			case (r.mode)
				MODE_ADD: begin
					if (slots.size() >= ENTRIES_DEF) begin
						e.status = ST_FULL;
					end else begin
						s.ip = r.target_ip;
						s.mac = r.hw_addr;
						s.ttl = r.ttl_value;
						slots.push_back(s);
					end
				end
				MODE_DEL: begin
					if (hit < 0)
						e.status = ST_MISS;
					else
						slots.delete(hit);
				end
				MODE_FIND: begin
					if (hit < 0) begin
						e.status = ST_MISS;
					end else begin
						e.found_hw_addr = slots[hit].mac;
						e.found_ttl = slots[hit].ttl;
					end
				end
				default: ;
			endcase
			e.entry_count = 5'(slots.size());
			replies.push_back(e);
		endfunction

		function void compare_reply(rsp_t a);
			rsp_t e;
			if (replies.size() == 0) begin
				$error("reply with nothing outstanding: %h", a);
				errors++;
				return;
			end
			e = replies.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status);
				errors++;
			end
			if (a.found_hw_addr !== e.found_hw_addr) begin
				$error("found_hw_addr: expected %h, got %h",
					e.found_hw_addr, a.found_hw_addr);
				errors++;
			end
			if (a.found_ttl !== e.found_ttl) begin
				$error("found_ttl: expected %h, got %h", e.found_ttl, a.found_ttl);
				errors++;
			end
			if (a.entry_count !== e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, a.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	arp_shadow_table shadow = new();
	int unsigned idle_pct = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rsp_hold = 0;
	logic [31:0] ip_pool [8];

	arp_cache_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// receiver: stall in short bursts while idling is enabled
	always @(negedge clk) begin
		if (rsp_hold != 0) begin
			rsp_stall <= 1'b1;
			rsp_hold--;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			rsp_stall <= 1'b1;
			rsp_hold = $urandom_range(0, 2);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (req_valid && !req_stall)
			shadow.apply_request(req);
		if (rsp_valid && !rsp_stall)
			shadow.compare_reply(rsp);
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic req_t make_req(logic [1:0] mode, logic [31:0] ip,
		logic [47:0] mac, logic [15:0] ttl);
		req_t r;
		r.mode = mode;
		r.target_ip = ip;
		r.hw_addr = mac;
		r.ttl_value = ttl;
		return r;
	endfunction

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	task automatic send_item(input req_t item);
		int unsigned gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	// hold off the sender until every reply is back
	task automatic drain_replies();
		@(negedge clk);
		req_valid <= 1'b0;
		while (shadow.waiting() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send_item(make_req(MODE_FIND, 32'h0, 48'h0, 16'h0));
		send_item(make_req(MODE_DEL, 32'hFFFF_FFFF, 48'h0, 16'h0));
		send_item(make_req(MODE_ADD, 32'h0, 48'h0, 16'h0));
		send_item(make_req(MODE_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF));
		// same IP again; delete and find must act on the older one
		send_item(make_req(MODE_ADD, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 16'h0001));
		send_item(make_req(MODE_FIND, 32'hFFFF_FFFF, 48'h0, 16'h0));
		send_item(make_req(MODE_DEL, 32'hFFFF_FFFF, 48'h0, 16'h0));
		send_item(make_req(MODE_FIND, 32'hFFFF_FFFF, 48'h0, 16'h0));
		send_item(make_req(MODE_NOP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF));
		// fill to capacity, then one add too many
		for (int i = 0; i < 15; i++)
			send_item(make_req(MODE_ADD, 32'h0101_0101 * (i + 1), rand_mac(),
				16'($urandom)));
	endtask

	task automatic run_random();
		req_t        r;
		int unsigned roll;
		int unsigned add_pct;
		int unsigned del_pct;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				// pick a filling or a draining phase at random so both full and empty recur
				if ($urandom_range(0, 1)) begin
					add_pct = 55;
					del_pct = 20;
				end else begin
					add_pct = 20;
					del_pct = 55;
				end
				idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
			end
			if (n == RANDOM_ITEMS / 2)
				drain_replies();
			if (n >= RANDOM_ITEMS - 150)
				idle_pct = 0;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				r.mode = MODE_NOP;
			else if (roll < 3 + add_pct)
				r.mode = MODE_ADD;
			else if (roll < 3 + add_pct + del_pct)
				r.mode = MODE_DEL;
			else
				r.mode = MODE_FIND;
			if ($urandom_range(0, 99) < 80)
				r.target_ip = ip_pool[$urandom_range(0, 7)];
			else
				r.target_ip = $urandom;
			r.hw_addr = rand_mac();
			r.ttl_value = 16'($urandom);
			send_item(r);
		end
	endtask

	initial begin
		ip_pool[0] = 32'h0;
		ip_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++)
			ip_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 25;
		run_directed();
		send_item(make_req(MODE_ADD, 32'hDEAD_BEEF, rand_mac(), 16'h8000));
		drain_replies();
		run_random();

		@(negedge clk);
		req_valid <= 1'b0;
		while (shadow.waiting() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (shadow.errors == 0 && shadow.waiting() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
